@@ rtl/core/svm_pkg.sv @@
// svm_pkg: opcodes, fault codes and controller/datapath command types
// for the stack machine executor; no dependencies
package svm_pkg;

  typedef enum logic [4:0] {
    OP_START  = 5'd0,  OP_ALLOC = 5'd1,  OP_DALLOC = 5'd2,  OP_CALL = 5'd3,
    OP_RETURN = 5'd4,  OP_HLT   = 5'd5,  OP_RD     = 5'd6,  OP_PRN  = 5'd7,
    OP_LDC    = 5'd8,  OP_LDV   = 5'd9,  OP_ADD    = 5'd10, OP_SUB  = 5'd11,
    OP_MULT   = 5'd12, OP_DIV   = 5'd13, OP_INV    = 5'd14, OP_AND  = 5'd15,
    OP_OR     = 5'd16, OP_NEG   = 5'd17, OP_CME    = 5'd18, OP_CMA  = 5'd19,
    OP_CEQ    = 5'd20, OP_CDIF  = 5'd21, OP_CMEQ   = 5'd22, OP_CMAQ = 5'd23,
    OP_STR    = 5'd24, OP_JMP   = 5'd25, OP_JMPF   = 5'd26, OP_NULL = 5'd27
  } opcode_e;

  typedef enum logic [1:0] {
    FAULT_NONE  = 2'd0,
    FAULT_DIV0  = 2'd1,
    FAULT_STACK = 2'd2,
    FAULT_ADDR  = 2'd3
  } fault_e;

  // datapath operations requested by the controller
  typedef enum logic [3:0] {
    DP_NONE,      // nothing
    DP_RD_TOP,    // read mem[sp] into b
    DP_RD_SUB,    // read mem[sp-1] into a
    DP_RD_ADDR,   // read mem[ptr] into b
    DP_WR_TOP1,   // write w to mem[sp+1], sp++
    DP_WR_SUB,    // write w to mem[sp-1], sp--
    DP_WR_TOP,    // write w to mem[sp]
    DP_WR_ADDR,   // write w to mem[ptr], sp--
    DP_DIV_START, // start divider
    DP_SP_DEC,    // sp--
    DP_SP_SET     // sp = -1
  } dp_op_e;

  typedef enum logic [2:0] {
    WSEL_B, WSEL_RV, WSEL_OPV, WSEL_NEXT, WSEL_ALU, WSEL_DIV
  } wsel_e;

  typedef struct packed {
    dp_op_e op;
    wsel_e  wsel;
  } dp_cmd_t;

  typedef struct packed {
    logic clr_busy;
    logic div_busy;
    logic b_zero;
  } dp_sts_t;

endpackage

@@ rtl/core/svm_datapath.sv @@
// svm_datapath: data memory, stack pointer, operand registers, alu and
// restoring divider; uses svm_pkg
module svm_datapath #(
  parameter int MemDepth  = 64,
  parameter int DataWidth = 32,
  parameter int AddrW     = 6
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  svm_pkg::dp_cmd_t       cmd_i,
  input  svm_pkg::opcode_e       op_i,
  input  logic [AddrW-1:0]       ptr_i,
  input  logic [DataWidth-1:0]   rv_i,
  input  logic [DataWidth-1:0]   opv_i,
  input  logic [DataWidth-1:0]   next_i,
  output svm_pkg::dp_sts_t       sts_o,
  output logic signed [AddrW:0]  sp_o,
  output logic [DataWidth-1:0]   b_o
);

  localparam int CntW = $clog2(DataWidth + 1);

  logic [DataWidth-1:0] mem_q [MemDepth];
  logic signed [AddrW:0] sp_q, sp_d;
  logic [DataWidth-1:0] a_q, b_q, w, alu;
  logic [AddrW-1:0] waddr, raddr;
  logic we;
  logic [DataWidth-1:0] rdata_q;
  logic signed [DataWidth-1:0] sa, sb;
  logic clr_q;
  logic [AddrW-1:0] clr_addr_q;

  // divider state
  logic [DataWidth-1:0] quo_q, rem_q, dvs_q;
  logic [CntW-1:0] cnt_q;
  logic neg_q, busy_q;
  logic [DataWidth:0] trial;
  logic [DataWidth-1:0] rem_sh, divres;

  assign sa = a_q;
  assign sb = b_q;

  always_comb begin
    unique case (op_i)
      svm_pkg::OP_ADD:  alu = a_q + b_q;
      svm_pkg::OP_SUB:  alu = a_q - b_q;
      svm_pkg::OP_MULT: alu = a_q * b_q;
      svm_pkg::OP_INV:  alu = '0 - b_q;
      svm_pkg::OP_NEG:  alu = DataWidth'(1) - b_q;
      svm_pkg::OP_AND:  alu = DataWidth'((a_q == DataWidth'(1)) && (b_q == DataWidth'(1)));
      svm_pkg::OP_OR:   alu = DataWidth'((a_q == DataWidth'(1)) || (b_q == DataWidth'(1)));
      svm_pkg::OP_CME:  alu = DataWidth'(sa < sb);
      svm_pkg::OP_CMA:  alu = DataWidth'(sa > sb);
      svm_pkg::OP_CEQ:  alu = DataWidth'(sa == sb);
      svm_pkg::OP_CDIF: alu = DataWidth'(sa != sb);
      svm_pkg::OP_CMEQ: alu = DataWidth'(sa <= sb);
      svm_pkg::OP_CMAQ: alu = DataWidth'(sa >= sb);
      default:          alu = b_q;
    endcase
  end

  assign divres = neg_q ? ('0 - quo_q) : quo_q;

  always_comb begin
    unique case (cmd_i.wsel)
      svm_pkg::WSEL_B:    w = b_q;
      svm_pkg::WSEL_RV:   w = rv_i;
      svm_pkg::WSEL_OPV:  w = opv_i;
      svm_pkg::WSEL_NEXT: w = next_i;
      svm_pkg::WSEL_ALU:  w = alu;
      svm_pkg::WSEL_DIV:  w = divres;
      default:            w = b_q;
    endcase
  end

  always_comb begin
    we    = 1'b0;
    waddr = ptr_i;
    raddr = sp_q[AddrW-1:0];
    sp_d  = sp_q;
    unique case (cmd_i.op)
      svm_pkg::DP_RD_SUB:  raddr = AddrW'(sp_q - 1);
      svm_pkg::DP_RD_ADDR: raddr = ptr_i;
      svm_pkg::DP_WR_TOP1: begin
        we = 1'b1; waddr = AddrW'(sp_q + 1); sp_d = sp_q + (AddrW+1)'(1);
      end
      svm_pkg::DP_WR_SUB: begin
        we = 1'b1; waddr = AddrW'(sp_q - 1); sp_d = sp_q - (AddrW+1)'(1);
      end
      svm_pkg::DP_WR_TOP: begin
        we = 1'b1; waddr = sp_q[AddrW-1:0];
      end
      svm_pkg::DP_WR_ADDR: begin
        we = 1'b1; sp_d = sp_q - (AddrW+1)'(1);
      end
      svm_pkg::DP_SP_DEC: sp_d = sp_q - (AddrW+1)'(1);
      svm_pkg::DP_SP_SET: sp_d = '1;
      default: ;
    endcase
  end

  // clearing pass after reset, one word per cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q      <= 1'b1;
      clr_addr_q <= '0;
    end else if (clr_q) begin
      clr_addr_q <= clr_addr_q + 1'b1;
      clr_q      <= (clr_addr_q != AddrW'(MemDepth - 1));
    end
  end

  // memory: synchronous read, one write port
  always_ff @(posedge clk_i) begin
    if (clr_q) begin
      mem_q[clr_addr_q] <= '0;
    end else if (we) begin
      mem_q[waddr] <= w;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr];
  end

  // read data is registered in rdata_q, then loaded into a or b as the registered ld_q selects
  logic [1:0] ld_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ld_q <= 2'd0;
      sp_q <= '0;
    end else begin
      sp_q <= sp_d;
      ld_q <= (cmd_i.op == svm_pkg::DP_RD_SUB) ? 2'd1 :
              ((cmd_i.op == svm_pkg::DP_RD_TOP || cmd_i.op == svm_pkg::DP_RD_ADDR)
               ? 2'd2 : 2'd0);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld_q == 2'd1) a_q <= rdata_q;
    if (ld_q == 2'd2) b_q <= rdata_q;
  end

  // restoring divider on magnitudes, one quotient bit per cycle
  assign rem_sh = {rem_q[DataWidth-2:0], quo_q[DataWidth-1]};
  assign trial  = {1'b0, rem_sh} - {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (cmd_i.op == svm_pkg::DP_DIV_START) begin
      busy_q <= 1'b1;
      cnt_q  <= CntW'(DataWidth);
    end else if (busy_q) begin
      cnt_q  <= cnt_q - 1'b1;
      busy_q <= (cnt_q != CntW'(1));
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == svm_pkg::DP_DIV_START) begin
      quo_q <= a_q[DataWidth-1] ? ('0 - a_q) : a_q;
      dvs_q <= b_q[DataWidth-1] ? ('0 - b_q) : b_q;
      rem_q <= '0;
      neg_q <= a_q[DataWidth-1] ^ b_q[DataWidth-1];
    end else if (busy_q) begin
      if (!trial[DataWidth]) begin
        rem_q <= trial[DataWidth-1:0];
        quo_q <= {quo_q[DataWidth-2:0], 1'b1};
      end else begin
        rem_q <= rem_sh;
        quo_q <= {quo_q[DataWidth-2:0], 1'b0};
      end
    end
  end

  assign sts_o.clr_busy = clr_q;
  assign sts_o.div_busy = busy_q;
  assign sts_o.b_zero   = (b_q == '0);
  assign sp_o = sp_q;
  assign b_o  = b_q;

endmodule

@@ rtl/core/svm_ctrl.sv @@
// svm_ctrl: instruction sequencer, checks, block copy counter, program
// line and result register; uses svm_pkg, drives svm_datapath
module svm_ctrl #(
  parameter int MemDepth  = 64,
  parameter int ProgDepth = 256,
  parameter int DataWidth = 32,
  parameter int AddrW     = 6,
  parameter int LineW     = 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [4:0]            opcode_i,
  input  logic signed [31:0]    operand_value_i,
  input  logic [6:0]            block_count_i,
  input  logic [7:0]            jump_line_i,
  input  logic signed [31:0]    read_value_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [7:0]            next_line_o,
  output logic                  halted_o,
  output logic                  print_valid_o,
  output logic signed [31:0]    print_value_o,
  output logic [1:0]            fault_o,
  output svm_pkg::dp_cmd_t      cmd_o,
  output svm_pkg::opcode_e      op_o,
  output logic [AddrW-1:0]      ptr_o,
  output logic [DataWidth-1:0]  next_o,
  output logic [DataWidth-1:0]  opv_o,
  output logic [DataWidth-1:0]  rv_o,
  input  svm_pkg::dp_sts_t      sts_i,
  input  logic signed [AddrW:0] sp_i,
  input  logic [DataWidth-1:0]  b_i
);

  typedef enum logic [10:0] {
    S_IDLE  = 11'b00000000001,
    S_CHECK = 11'b00000000010,
    S_RD1   = 11'b00000000100,
    S_RD2   = 11'b00000001000,
    S_WAIT  = 11'b00000010000,
    S_EXEC  = 11'b00000100000,
    S_DIVW  = 11'b00001000000,
    S_CPRD  = 11'b00010000000,
    S_CPWT  = 11'b00100000000,
    S_CPWR  = 11'b01000000000,
    S_DONE  = 11'b10000000000
  } state_e;

  state_e state_q, state_d;
  svm_pkg::opcode_e op_q;
  logic signed [32:0] opv_q;
  logic signed [31:0] rv_q;
  logic [6:0] cnt_q, cnt_d;
  logic [7:0] jl_q;
  logic [LineW-1:0] line_q, line_d;
  logic [LineW-1:0] nxt;
  logic rd2_q, rd2_d;
  logic [AddrW:0] k_q, k_d;
  logic take;

  logic out_valid_q, out_valid_d;
  logic [7:0] res_line_q, res_line_d;
  logic halted_q, halted_d, pv_q, pv_d;
  logic [31:0] pval_q, pval_d;
  svm_pkg::fault_e fault_q, fault_d;

  logic is_bin, addr_ok, blk_ok, jl_ok, push_ok, pop1, pop2;
  logic signed [AddrW+8:0] spx;
  logic signed [DataWidth-1:0] bs;

  assign nxt  = line_q + 1'b1;
  assign spx  = (AddrW+9)'(sp_i);
  assign bs   = b_i;
  assign is_bin = (op_q >= svm_pkg::OP_ADD) && (op_q <= svm_pkg::OP_CMAQ) &&
                  (op_q != svm_pkg::OP_INV) && (op_q != svm_pkg::OP_NEG);
  assign addr_ok = (opv_q >= 0) && (opv_q < MemDepth);
  assign blk_ok  = (opv_q >= 0) && (opv_q + $signed({1'b0, cnt_q}) <= MemDepth);
  assign jl_ok   = ({24'd0, jl_q} < ProgDepth);
  assign push_ok = (spx + 1 < MemDepth);
  assign pop1    = (sp_i >= 0);
  assign pop2    = (sp_i >= 1);

  assign op_o   = op_q;
  assign next_o = DataWidth'(nxt);
  assign opv_o  = DataWidth'(opv_q);
  assign rv_o   = DataWidth'(rv_q);
  assign in_stall_o = (state_q != S_IDLE) || sts_i.clr_busy;
  assign take   = in_valid_i && !in_stall_o;

  always_comb begin
    state_d = state_q;
    cmd_o   = '{op: svm_pkg::DP_NONE, wsel: svm_pkg::WSEL_B};
    ptr_o   = opv_q[AddrW-1:0];
    line_d  = line_q;
    cnt_d   = cnt_q;
    k_d     = k_q;
    rd2_d   = rd2_q;
    out_valid_d = out_valid_q && out_stall_i;
    res_line_d = res_line_q;
    halted_d = halted_q; pv_d = pv_q; pval_d = pval_q; fault_d = fault_q;

    unique case (state_q)
      S_IDLE: if (take) state_d = S_CHECK;
      S_CHECK: begin
        fault_d  = svm_pkg::FAULT_NONE;
        halted_d = 1'b0; pv_d = 1'b0; pval_d = '0;
        res_line_d = 8'(line_q);
        state_d  = S_DONE;
        rd2_d    = 1'b0;
        k_d      = '0;
        if (is_bin) begin
          if (!pop2) fault_d = svm_pkg::FAULT_STACK;
          else begin state_d = S_RD1; rd2_d = 1'b1; end
        end else begin
          unique case (op_q)
            svm_pkg::OP_START: begin
              cmd_o.op = svm_pkg::DP_SP_SET; res_line_d = 8'(nxt); line_d = nxt;
            end
            svm_pkg::OP_ALLOC, svm_pkg::OP_DALLOC: begin
              if (!blk_ok) fault_d = svm_pkg::FAULT_ADDR;
              else if (op_q == svm_pkg::OP_ALLOC &&
                       spx + $signed({1'b0, cnt_q}) > MemDepth - 1)
                fault_d = svm_pkg::FAULT_STACK;
              else if (op_q == svm_pkg::OP_DALLOC &&
                       $signed({1'b0, cnt_q}) > spx + 1)
                fault_d = svm_pkg::FAULT_STACK;
              else begin
                res_line_d = 8'(nxt); line_d = nxt;
                state_d = (cnt_q == 7'd0) ? S_DONE : S_CPRD;
                if (op_q == svm_pkg::OP_DALLOC) k_d = (AddrW+1)'(cnt_q - 1'b1);
              end
            end
            svm_pkg::OP_CALL: begin
              if (!jl_ok) fault_d = svm_pkg::FAULT_ADDR;
              else if (!push_ok) fault_d = svm_pkg::FAULT_STACK;
              else begin
                cmd_o = '{op: svm_pkg::DP_WR_TOP1, wsel: svm_pkg::WSEL_NEXT};
                res_line_d = jl_q; line_d = LineW'(jl_q);
              end
            end
            svm_pkg::OP_RETURN, svm_pkg::OP_PRN, svm_pkg::OP_INV,
            svm_pkg::OP_NEG, svm_pkg::OP_JMPF: begin
              if (op_q == svm_pkg::OP_JMPF && !jl_ok) fault_d = svm_pkg::FAULT_ADDR;
              else if (!pop1) fault_d = svm_pkg::FAULT_STACK;
              else state_d = S_RD2;
            end
            svm_pkg::OP_HLT: halted_d = 1'b1;
            svm_pkg::OP_RD, svm_pkg::OP_LDC: begin
              if (!push_ok) fault_d = svm_pkg::FAULT_STACK;
              else begin
                cmd_o = '{op: svm_pkg::DP_WR_TOP1,
                          wsel: (op_q == svm_pkg::OP_RD) ? svm_pkg::WSEL_RV
                                                         : svm_pkg::WSEL_OPV};
                res_line_d = 8'(nxt); line_d = nxt;
              end
            end
            svm_pkg::OP_LDV: begin
              if (!addr_ok) fault_d = svm_pkg::FAULT_ADDR;
              else if (!push_ok) fault_d = svm_pkg::FAULT_STACK;
              else state_d = S_RD2;
            end
            svm_pkg::OP_STR: begin
              if (!addr_ok) fault_d = svm_pkg::FAULT_ADDR;
              else if (!pop1) fault_d = svm_pkg::FAULT_STACK;
              else state_d = S_RD2;
            end
            svm_pkg::OP_JMP: begin
              if (!jl_ok) fault_d = svm_pkg::FAULT_ADDR;
              else begin res_line_d = jl_q; line_d = LineW'(jl_q); end
            end
            svm_pkg::OP_NULL: begin res_line_d = 8'(nxt); line_d = nxt; end
            default: ;
          endcase
        end
      end
      S_RD1: begin cmd_o.op = svm_pkg::DP_RD_SUB; state_d = S_RD2; end
      S_RD2: begin
        cmd_o.op = (op_q == svm_pkg::OP_LDV) ? svm_pkg::DP_RD_ADDR : svm_pkg::DP_RD_TOP;
        state_d = S_WAIT;
      end
      S_WAIT: state_d = S_EXEC;
      S_EXEC: begin
        state_d = S_DONE;
        res_line_d = 8'(nxt); line_d = nxt;
        if (rd2_q) begin
          if (op_q == svm_pkg::OP_DIV) begin
            if (sts_i.b_zero) begin
              fault_d = svm_pkg::FAULT_DIV0; res_line_d = 8'(line_q); line_d = line_q;
            end else begin
              cmd_o.op = svm_pkg::DP_DIV_START; state_d = S_DIVW;
              res_line_d = 8'(line_q); line_d = line_q;
            end
          end else cmd_o = '{op: svm_pkg::DP_WR_SUB, wsel: svm_pkg::WSEL_ALU};
        end else begin
          unique case (op_q)
            svm_pkg::OP_RETURN: begin
              if (bs < 0 || bs >= ProgDepth) begin
                fault_d = svm_pkg::FAULT_ADDR; res_line_d = 8'(line_q); line_d = line_q;
              end else begin
                cmd_o.op = svm_pkg::DP_SP_DEC;
                res_line_d = 8'(b_i); line_d = LineW'(b_i);
              end
            end
            svm_pkg::OP_PRN: begin
              cmd_o.op = svm_pkg::DP_SP_DEC; pv_d = 1'b1; pval_d = 32'(bs);
            end
            svm_pkg::OP_INV, svm_pkg::OP_NEG:
              cmd_o = '{op: svm_pkg::DP_WR_TOP, wsel: svm_pkg::WSEL_ALU};
            svm_pkg::OP_JMPF: begin
              cmd_o.op = svm_pkg::DP_SP_DEC;
              if (b_i == '0) begin res_line_d = jl_q; line_d = LineW'(jl_q); end
            end
            svm_pkg::OP_LDV:
              cmd_o = '{op: svm_pkg::DP_WR_TOP1, wsel: svm_pkg::WSEL_B};
            default:
              cmd_o = '{op: svm_pkg::DP_WR_ADDR, wsel: svm_pkg::WSEL_B};
          endcase
        end
      end
      S_DIVW: if (!sts_i.div_busy) begin
        cmd_o = '{op: svm_pkg::DP_WR_SUB, wsel: svm_pkg::WSEL_DIV};
        res_line_d = 8'(nxt); line_d = nxt; state_d = S_DONE;
      end
      S_CPRD: begin
        // alloc reads source block, dalloc reads stack top
        if (op_q == svm_pkg::OP_ALLOC) begin
          cmd_o.op = svm_pkg::DP_RD_ADDR; ptr_o = AddrW'(opv_q) + AddrW'(k_q);
        end else cmd_o.op = svm_pkg::DP_RD_TOP;
        state_d = S_CPWT;
      end
      S_CPWT: state_d = S_CPWR;
      S_CPWR: begin
        if (op_q == svm_pkg::OP_ALLOC) begin
          cmd_o = '{op: svm_pkg::DP_WR_TOP1, wsel: svm_pkg::WSEL_B};
          k_d = k_q + 1'b1;
        end else begin
          cmd_o = '{op: svm_pkg::DP_WR_ADDR, wsel: svm_pkg::WSEL_B};
          ptr_o = AddrW'(opv_q) + AddrW'(k_q);
          k_d = k_q - 1'b1;
        end
        cnt_d = cnt_q - 1'b1;
        state_d = (cnt_q == 7'd1) ? S_DONE : S_CPRD;
      end
      S_DONE: if (!out_valid_q || !out_stall_i) begin
        out_valid_d = 1'b1; state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      line_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      line_q  <= line_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      op_q  <= svm_pkg::opcode_e'(opcode_i);
      opv_q <= 33'(operand_value_i);
      rv_q  <= read_value_i;
      cnt_q <= block_count_i;
      jl_q  <= jump_line_i;
    end else cnt_q <= cnt_d;
    k_q   <= k_d;
    rd2_q <= rd2_d;
    res_line_q <= res_line_d;
    halted_q <= halted_d; pv_q <= pv_d; pval_q <= pval_d; fault_q <= fault_d;
  end

  // result register holds until taken
  logic [7:0] o_line_q; logic o_h_q, o_pv_q; logic [31:0] o_pval_q; logic [1:0] o_f_q;
  always_ff @(posedge clk_i) begin
    if (state_q == S_DONE && (!out_valid_q || !out_stall_i)) begin
      o_line_q <= res_line_q; o_h_q <= halted_q; o_pv_q <= pv_q;
      o_pval_q <= pval_q; o_f_q <= fault_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign next_line_o   = o_line_q;
  assign halted_o      = o_h_q;
  assign print_valid_o = o_pv_q;
  assign print_value_o = o_pval_q;
  assign fault_o       = o_f_q;

endmodule

@@ rtl/core/stack_vm_instruction_executor_unit.sv @@
// Stack machine executor: one decoded instruction per input transfer,
// one result transfer each; the input stalls until the last result is
// registered. HLT, START, RD, LDC, CALL, JMP, NULL, undefined opcodes and
// any instruction faulting in its checks go from check straight to done;
// RETURN, PRN, INV, NEG, JMPF, LDV and STR read one word, then execute;
// two-operand ops read two; DIV then waits for the divider, which makes
// one quotient bit per cycle; ALLOC/DALLOC copy word by word, a read then
// a write each. A stalled output holds the unit in its done state. After
// reset the data memory is cleared one word per cycle with the input
// stalled.
// top level; instantiates svm_ctrl and svm_datapath; uses svm_pkg
module stack_vm_instruction_executor_unit #(
  parameter int MEM_DEPTH  = 64,
  parameter int PROG_DEPTH = 256,
  parameter int DATA_WIDTH = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [4:0]         opcode_i,
  input  logic signed [31:0] operand_value_i,
  input  logic [6:0]         block_count_i,
  input  logic [7:0]         jump_line_i,
  input  logic signed [31:0] read_value_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [7:0]         next_line_o,
  output logic               halted_o,
  output logic               print_valid_o,
  output logic signed [31:0] print_value_o,
  output logic [1:0]         fault_o
);

  localparam int AddrW = $clog2(MEM_DEPTH);
  localparam int LineW = $clog2(PROG_DEPTH);

  svm_pkg::dp_cmd_t cmd;
  svm_pkg::dp_sts_t sts;
  svm_pkg::opcode_e op;
  logic [AddrW-1:0] ptr;
  logic [DATA_WIDTH-1:0] nxt, b, opv, rv;
  logic signed [AddrW:0] sp;

  svm_ctrl #(
    .MemDepth(MEM_DEPTH), .ProgDepth(PROG_DEPTH), .DataWidth(DATA_WIDTH),
    .AddrW(AddrW), .LineW(LineW)
  ) u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .opcode_i, .operand_value_i,
    .block_count_i, .jump_line_i, .read_value_i, .out_valid_o, .out_stall_i,
    .next_line_o, .halted_o, .print_valid_o, .print_value_o, .fault_o,
    .cmd_o(cmd), .op_o(op), .ptr_o(ptr), .next_o(nxt), .opv_o(opv), .rv_o(rv),
    .sts_i(sts), .sp_i(sp), .b_i(b)
  );

  svm_datapath #(
    .MemDepth(MEM_DEPTH), .DataWidth(DATA_WIDTH), .AddrW(AddrW)
  ) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .op_i(op), .ptr_i(ptr),
    .rv_i(rv), .opv_i(opv),
    .next_i(nxt), .sts_o(sts), .sp_o(sp), .b_o(b)
  );

endmodule

@@ tb/stack_vm_instruction_executor_unit_test.sv @@
// testbench for stack_vm_instruction_executor_unit: drives decoded instructions,
// predicts each result in a scoreboard class and compares it at the output
// depends on svm_pkg and the unit under test
module stack_vm_instruction_executor_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MEM_WORDS = 64;
  localparam int PROG_LINES = 256;
  localparam int IDLE_LIMIT = 20000;

  typedef struct packed {
    logic [7:0]  next_line;
    logic        halted;
    logic        print_valid;
    logic [31:0] print_value;
    logic [1:0]  fault;
  } vm_result_t;

  class vm_scoreboard;
    logic [31:0] mem [MEM_WORDS];
    int          sp;
    int          line;
    vm_result_t  pending[$];
    int          errors;
    int          checked;
    int          fault_seen[4];

    function new();
      foreach (mem[i]) mem[i] = '0;
      sp = 0;
      line = 0;
      errors = 0;
      checked = 0;
    endfunction

    function void note_instruction(logic [4:0] op, logic signed [31:0] opv,
                                   logic [6:0] cnt, logic [7:0] jl,
                                   logic signed [31:0] rv);
      vm_result_t  r;
      int          nsp;
      int          nxt;
      svm_pkg::fault_e f;
      logic [31:0] ua, ub, w;
      logic signed [31:0] a, b;
      longint      v;
      logic [31:0] copy [MEM_WORDS];
      bit          addr_ok, blk_ok, can_push;
      copy = mem;
      nsp = sp;
      nxt = (line + 1) % PROG_LINES;
      f = svm_pkg::FAULT_NONE;
      r = '0;
      addr_ok = opv >= 0 && opv < MEM_WORDS;
      blk_ok = opv >= 0 && longint'(opv) + longint'(cnt) <= MEM_WORDS;
      can_push = sp + 1 < MEM_WORDS;
      if (op >= svm_pkg::OP_ADD && op <= svm_pkg::OP_CMAQ && op != svm_pkg::OP_INV &&
          op != svm_pkg::OP_NEG) begin
        if (sp < 1) f = svm_pkg::FAULT_STACK;
        else begin
          ua = copy[sp - 1];
          ub = copy[sp];
          a = ua;
          b = ub;
          w = '0;
          case (op)
            svm_pkg::OP_ADD: w = ua + ub;
            svm_pkg::OP_SUB: w = ua - ub;
            svm_pkg::OP_MULT: w = ua * ub;
            svm_pkg::OP_DIV: begin
              if (b == 0) f = svm_pkg::FAULT_DIV0;
              else if (b == -1) w = -ua;
              else w = a / b;
            end
            svm_pkg::OP_AND: w = (a == 1 && b == 1);
            svm_pkg::OP_OR: w = (a == 1 || b == 1);
            svm_pkg::OP_CME: w = a < b;
            svm_pkg::OP_CMA: w = a > b;
            svm_pkg::OP_CEQ: w = a == b;
            svm_pkg::OP_CDIF: w = a != b;
            svm_pkg::OP_CMEQ: w = a <= b;
            default: w = a >= b;
          endcase
          if (f == svm_pkg::FAULT_NONE) begin
            copy[sp - 1] = w;
            nsp = sp - 1;
          end
        end
      end else begin
        case (op)
          svm_pkg::OP_START: nsp = -1;
          svm_pkg::OP_ALLOC: begin
            if (!blk_ok) f = svm_pkg::FAULT_ADDR;
            else if (sp + int'(cnt) > MEM_WORDS - 1) f = svm_pkg::FAULT_STACK;
            else for (int k = 0; k < int'(cnt); k++) begin
              nsp++;
              copy[nsp] = copy[opv + k];
            end
          end
          svm_pkg::OP_DALLOC: begin
            if (!blk_ok) f = svm_pkg::FAULT_ADDR;
            else if (int'(cnt) > sp + 1) f = svm_pkg::FAULT_STACK;
            else for (int k = int'(cnt) - 1; k >= 0; k--) begin
              copy[opv + k] = copy[nsp];
              nsp--;
            end
          end
          svm_pkg::OP_CALL: begin
            if (!can_push) f = svm_pkg::FAULT_STACK;
            else begin
              nsp++;
              copy[nsp] = nxt;
              nxt = jl;
            end
          end
          svm_pkg::OP_RETURN: begin
            if (sp < 0) f = svm_pkg::FAULT_STACK;
            else begin
              v = $signed(copy[sp]);
              if (v < 0 || v >= PROG_LINES) f = svm_pkg::FAULT_ADDR;
              else begin
                nxt = v;
                nsp--;
              end
            end
          end
          svm_pkg::OP_HLT: begin
            r.halted = 1'b1;
            nxt = line;
          end
          svm_pkg::OP_RD, svm_pkg::OP_LDC: begin
            if (!can_push) f = svm_pkg::FAULT_STACK;
            else begin
              nsp++;
              copy[nsp] = (op == svm_pkg::OP_RD) ? rv : opv;
            end
          end
          svm_pkg::OP_PRN: begin
            if (sp < 0) f = svm_pkg::FAULT_STACK;
            else begin
              r.print_valid = 1'b1;
              r.print_value = copy[sp];
              nsp--;
            end
          end
          svm_pkg::OP_LDV: begin
            if (!addr_ok) f = svm_pkg::FAULT_ADDR;
            else if (!can_push) f = svm_pkg::FAULT_STACK;
            else begin
              w = copy[opv];
              nsp++;
              copy[nsp] = w;
            end
          end
          svm_pkg::OP_INV, svm_pkg::OP_NEG: begin
            if (sp < 0) f = svm_pkg::FAULT_STACK;
            else copy[sp] = (op == svm_pkg::OP_INV) ? -copy[sp] : 32'd1 - copy[sp];
          end
          svm_pkg::OP_STR: begin
            if (!addr_ok) f = svm_pkg::FAULT_ADDR;
            else if (sp < 0) f = svm_pkg::FAULT_STACK;
            else begin
              copy[opv] = copy[sp];
              nsp--;
            end
          end
          svm_pkg::OP_JMP: nxt = jl;
          svm_pkg::OP_JMPF: begin
            if (sp < 0) f = svm_pkg::FAULT_STACK;
            else begin
              if (copy[sp] == 0) nxt = jl;
              nsp--;
            end
          end
          svm_pkg::OP_NULL: ;
          default: nxt = line;
        endcase
      end
      if (f != svm_pkg::FAULT_NONE) begin
        r = '0;
        nxt = line;
      end else begin
        mem = copy;
        sp = nsp;
        line = nxt;
      end
      r.next_line = nxt;
      r.fault = f;
      fault_seen[f]++;
      pending.push_back(r);
    endfunction

    function void check_result(vm_result_t got);
      vm_result_t exp_r;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result %p", $time, got);
        errors++;
        return;
      end
      exp_r = pending.pop_front();
      checked++;
      if (got.next_line !== exp_r.next_line)
        $display("%0t: next_line exp %0d got %0d", $time, exp_r.next_line, got.next_line);
      if (got.halted !== exp_r.halted)
        $display("%0t: halted exp %0d got %0d", $time, exp_r.halted, got.halted);
      if (got.print_valid !== exp_r.print_valid)
        $display("%0t: print_valid exp %0d got %0d", $time, exp_r.print_valid,
                 got.print_valid);
      if (got.print_value !== exp_r.print_value)
        $display("%0t: print_value exp %0h got %0h", $time, exp_r.print_value,
                 got.print_value);
      if (got.fault !== exp_r.fault)
        $display("%0t: fault exp %0d got %0d", $time, exp_r.fault, got.fault);
      if (got !== exp_r) errors++;
    endfunction
  endclass

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_stall_o;
  logic [4:0]         opcode_i;
  logic signed [31:0] operand_value_i;
  logic [6:0]         block_count_i;
  logic [7:0]         jump_line_i;
  logic signed [31:0] read_value_i;
  logic               out_valid_o;
  logic               out_stall_i;
  logic [7:0]         next_line_o;
  logic               halted_o;
  logic               print_valid_o;
  logic signed [31:0] print_value_o;
  logic [1:0]         fault_o;

  vm_scoreboard sb;
  int  idle_cycles;
  int  sent;

  stack_vm_instruction_executor_unit uut (.*);

  always begin
    clk_i = 1'b1;
    #6;
    clk_i = 1'b0;
    #6;
  end

  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // valid stays high between back-to-back transfers
  task automatic send_instr(svm_pkg::opcode_e op, int opv, int cnt, int jl, int rv);
    int g;
    g = gap_len();
    @(negedge clk_i);
    if (g > 0) begin
      in_valid_i <= 1'b0;
      repeat (g) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    opcode_i <= op;
    operand_value_i <= opv;
    block_count_i <= 7'(cnt);
    jump_line_i <= 8'(jl);
    read_value_i <= rv;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_instruction(op, opv, 7'(cnt), 8'(jl), rv);
    sent++;
  endtask

  task automatic send_raw(logic [4:0] op, int opv, int cnt, int jl, int rv);
    send_instr(svm_pkg::opcode_e'(op), opv, cnt, jl, rv);
  endtask

  function automatic int rand_word();
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 3) - 1;
      1: return 32'h8000_0000;
      2: return 32'h7fff_ffff;
      3: return $urandom_range(0, 300);
      default: return $urandom;
    endcase
  endfunction

  function automatic int rand_addr();
    case ($urandom_range(0, 9))
      0: return -$urandom_range(1, 5);
      1: return $urandom_range(MEM_WORDS, MEM_WORDS + 4);
      2: return $urandom;
      default: return $urandom_range(0, MEM_WORDS - 1);
    endcase
  endfunction

  task automatic random_instr(bit wellformed);
    int op;
    if (wellformed) begin
      case ($urandom_range(0, 9))
        0, 1: op = svm_pkg::OP_LDC;
        2: op = svm_pkg::OP_RD;
        3: op = svm_pkg::OP_LDV;
        4: op = svm_pkg::OP_STR;
        5: op = $urandom_range(svm_pkg::OP_ADD, svm_pkg::OP_CMAQ);
        6: op = svm_pkg::OP_PRN;
        7: op = $urandom_range(0, 1) ? svm_pkg::OP_JMPF : svm_pkg::OP_JMP;
        8: op = $urandom_range(svm_pkg::OP_ALLOC, svm_pkg::OP_RETURN);
        default: op = $urandom_range(0, 31);
      endcase
      if (op == svm_pkg::OP_START && $urandom_range(0, 3) != 0) op = svm_pkg::OP_LDC;
    end else op = $urandom_range(0, 31);
    send_raw(5'(op), (op == svm_pkg::OP_LDC) ? rand_word() : rand_addr(),
             ($urandom_range(0, 7) == 0) ? $urandom_range(0, 127) : $urandom_range(0, 8),
             $urandom_range(0, 255), rand_word());
  endtask

  initial begin
    int g;
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if ($urandom_range(0, 3) == 0) begin
        g = gap_len();
        if (g > 0) begin
          out_stall_i <= 1'b1;
          repeat (g) @(negedge clk_i);
          out_stall_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      sb.check_result({next_line_o, halted_o, print_valid_o, print_value_o, fault_o});
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout at %0t", $time);
      $display("stack_vm_instruction_executor_unit test failed");
      $finish;
    end
  end

  initial begin
    sb = new();
    idle_cycles = 0;
    sent = 0;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    opcode_i = '0;
    operand_value_i = '0;
    block_count_i = '0;
    jump_line_i = '0;
    read_value_i = '0;
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;
    // directed part
    send_instr(svm_pkg::OP_PRN, 0, 0, 0, 0);
    send_instr(svm_pkg::OP_START, 0, 0, 0, 0);
    send_instr(svm_pkg::OP_ADD, 0, 0, 0, 0);
    send_instr(svm_pkg::OP_LDC, 32'h8000_0000, 0, 0, 0);
    send_instr(svm_pkg::OP_RD, 0, 0, 0, -1);
    send_instr(svm_pkg::OP_DIV, 0, 0, 0, 0);
    send_instr(svm_pkg::OP_LDC, 0, 0, 0, 0);
    send_instr(svm_pkg::OP_DIV, 0, 0, 0, 0);
    send_instr(svm_pkg::OP_LDV, -1, 0, 0, 0);
    send_instr(svm_pkg::OP_STR, MEM_WORDS, 0, 0, 0);
    send_instr(svm_pkg::OP_ALLOC, 60, 5, 0, 0);
    send_instr(svm_pkg::OP_ALLOC, 0, 64, 0, 0);
    send_instr(svm_pkg::OP_DALLOC, 1, 3, 0, 0);
    send_instr(svm_pkg::OP_CALL, 0, 0, 255, 0);
    send_instr(svm_pkg::OP_RETURN, 0, 0, 0, 0);
    send_instr(svm_pkg::OP_LDC, 300, 0, 0, 0);
    send_instr(svm_pkg::OP_RETURN, 0, 0, 0, 0);
    send_instr(svm_pkg::OP_JMPF, 0, 0, 17, 0);
    send_instr(svm_pkg::OP_JMP, 0, 0, 0, 0);
    send_instr(svm_pkg::OP_HLT, 0, 0, 0, 0);
    send_raw(5'd31, 32'h7fff_ffff, 127, 255, 32'h7fff_ffff);
    send_instr(svm_pkg::OP_NULL, 0, 0, 0, 0);
    send_instr(svm_pkg::OP_START, 0, 0, 0, 0);
    repeat (MEM_WORDS + 1) send_instr(svm_pkg::OP_LDC, $urandom, 0, 0, 0);
    // random part
    for (int i = 0; i < 700; i++) begin
      if ($urandom_range(0, 59) == 0) send_instr(svm_pkg::OP_START, 0, 0, 0, 0);
      random_instr($urandom_range(0, 9) != 0);
    end
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    $display("sent %0d instructions, checked %0d results", sent, sb.checked);
    $display("faults none/div0/stack/addr: %0d/%0d/%0d/%0d", sb.fault_seen[0],
             sb.fault_seen[1], sb.fault_seen[2], sb.fault_seen[3]);
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("stack_vm_instruction_executor_unit test passed");
    else
      $display("stack_vm_instruction_executor_unit test failed");
    $finish;
  end
endmodule
